// File: sv/ctcgd_pkg.sv
// types and constants shared by the greedy ctc decoder
`default_nettype none
package ctcgd_pkg;

  typedef struct packed {
    logic signed [15:0] class_score;
    logic               row_end;
    logic               sequence_end;
  } ctc_in_t;

  typedef struct packed {
    logic               symbol_valid;
    logic        [12:0] class_index;
    logic signed [15:0] symbol_score;
    logic               is_final;
    logic signed [15:0] average_score;
  } ctc_out_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_LOAD
  } state_t;

  localparam int SUM_W = 26;
  localparam int COUNT_W = 10;
  localparam int INDEX_W = 13;
  localparam int KEY_W = 14;
  localparam int ADDR_W = 3;

  localparam logic signed [SUM_W:0] SUM_MAX = 27'sd33554431;
  localparam logic signed [SUM_W:0] SUM_MIN = -27'sd33554432;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [KEY_W-1:0] KEY_COUNT_RESET = 14'd8192;

  localparam logic REG_KEY_COUNT = 1'b0;

  localparam logic [4:0] DIV_LAST_STEP = 5'd25;

  localparam logic [25:0] AVG_NEG_LIMIT = 26'd32768;
  localparam logic [25:0] AVG_POS_LIMIT = 26'd32767;
  localparam logic signed [15:0] AVG_MIN = -16'sd32768;
  localparam logic signed [15:0] AVG_MAX = 16'sd32767;

endpackage
`default_nettype wire

// File: sv/ctc_greedy_decoder_top.sv
// greedy ctc best-path decoder with iterative divider for the sequence mean
// a row result is on the output in the cycle after its last score is accepted
// a sequence end runs the divider in ST_DIV, then ST_LOAD loads the final result into the output register
// throughput: one score per cycle, a row end waits while the output is stalled
// input stalled after a sequence end while in ST_DIV and ST_LOAD, longer while the output is stalled
// reset (synchronous, active high) clears sequence state and sets key_count to 8192
`default_nettype none
module ctc_greedy_decoder_top
  import ctcgd_pkg::*;
#(
  parameter int MAX_CLASSES = 8192
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ctc_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ctc_out_t                 out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int CW = $clog2(MAX_CLASSES + 1);

  state_t state, state_next;

  logic [KEY_W-1:0]       key_count;
  logic signed [15:0]     best_score;
  logic [INDEX_W-1:0]     best_index;
  logic [CW-1:0]          column;
  logic [INDEX_W-1:0]     previous_index;
  logic                   previous_valid;
  logic signed [SUM_W-1:0] score_total;
  logic [COUNT_W-1:0]     symbol_count;

  logic [COUNT_W-1:0]     div_rem;
  logic [SUM_W-1:0]       div_quo;
  logic [COUNT_W-1:0]     div_den;
  logic                   div_neg;
  logic [4:0]             div_step;
  ctc_out_t               hold;

  logic                   accept;
  logic                   row_done;
  logic                   out_free;
  logic                   load_final;
  logic                   first_col;
  logic                   in_range;
  logic signed [15:0]     upd_score;
  logic [INDEX_W-1:0]     upd_index;
  logic                   emit;
  logic signed [SUM_W:0]  sum_wide;
  logic signed [SUM_W-1:0] sum_after;
  logic [COUNT_W-1:0]     count_after;
  logic [SUM_W-1:0]       sum_mag;
  logic [COUNT_W:0]       rem_sh;
  logic                   rem_ge;
  logic signed [15:0]     avg;

  // config port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KEY_COUNT) begin
      prdata = 32'(key_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= KEY_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_KEY_COUNT) begin
      key_count <= pwdata[KEY_W-1:0];
    end
  end

  // per-score argmax update
  assign row_done = in_data.row_end || in_data.sequence_end;
  assign out_free = !out_valid || !out_stall;
  assign accept = in_valid && !in_stall;
  assign first_col = (column == '0);
  assign in_range = (column < CW'(MAX_CLASSES));

  always_comb begin
    upd_score = best_score;
    upd_index = best_index;
    if (first_col) begin
      upd_score = in_data.class_score;
      upd_index = '0;
    end else if (in_range && in_data.class_score > best_score) begin
      upd_score = in_data.class_score;
      upd_index = INDEX_W'(column);
    end
  end

  assign emit = (!previous_valid || upd_index != previous_index) &&
                upd_index != '0 && {1'b0, upd_index} < key_count;

  always_comb begin
    sum_wide = {score_total[SUM_W-1], score_total} + (SUM_W+1)'(upd_score);
    sum_after = score_total;
    count_after = symbol_count;
    if (emit) begin
      if (sum_wide > SUM_MAX) begin
        sum_after = SUM_MAX[SUM_W-1:0];
      end else if (sum_wide < SUM_MIN) begin
        sum_after = SUM_MIN[SUM_W-1:0];
      end else begin
        sum_after = sum_wide[SUM_W-1:0];
      end
      if (symbol_count != COUNT_MAX) begin
        count_after = symbol_count + 1'b1;
      end
    end
    sum_mag = sum_after[SUM_W-1] ? SUM_W'(-sum_after) : SUM_W'(sum_after);
  end

  // iterative divider step
  assign rem_sh = {div_rem, div_quo[SUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den};

  always_comb begin
    avg = '0;
    if (div_den != '0) begin
      if (div_neg) begin
        avg = (div_quo > AVG_NEG_LIMIT) ? AVG_MIN : 16'(16'd0 - div_quo[15:0]);
      end else begin
        avg = (div_quo > AVG_POS_LIMIT) ? AVG_MAX : div_quo[15:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (accept && in_data.sequence_end) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_step == DIV_LAST_STEP) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    load_final = 1'b0;
    unique case (state)
      ST_RUN: begin
        in_stall = out_valid && out_stall && row_done;
      end
      ST_DIV: begin
        in_stall = 1'b1;
      end
      ST_LOAD: begin
        load_final = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      best_score <= '0;
      best_index <= '0;
      column <= '0;
      previous_index <= '0;
      previous_valid <= 1'b0;
      score_total <= '0;
      symbol_count <= '0;
    end else if (accept) begin
      best_score <= upd_score;
      best_index <= upd_index;
      if (row_done) begin
        column <= '0;
      end else if (in_range) begin
        column <= column + 1'b1;
      end
      if (in_data.sequence_end) begin
        previous_index <= '0;
        previous_valid <= 1'b0;
        score_total <= '0;
        symbol_count <= '0;
      end else if (row_done) begin
        previous_index <= upd_index;
        previous_valid <= 1'b1;
        score_total <= sum_after;
        symbol_count <= count_after;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      div_step <= '0;
    end else if (accept && in_data.sequence_end) begin
      div_step <= '0;
    end else if (state == ST_DIV) begin
      div_step <= div_step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.sequence_end) begin
      div_rem <= '0;
      div_quo <= sum_mag;
      div_den <= count_after;
      div_neg <= sum_after[SUM_W-1];
      hold.symbol_valid <= emit;
      hold.class_index <= upd_index;
      hold.symbol_score <= upd_score;
      hold.is_final <= 1'b1;
      hold.average_score <= '0;
    end else if (state == ST_DIV) begin
      div_rem <= rem_ge ? COUNT_W'(rem_sh - {1'b0, div_den}) : rem_sh[COUNT_W-1:0];
      div_quo <= {div_quo[SUM_W-2:0], rem_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_final || (accept && row_done && !in_data.sequence_end)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_final) begin
      out_data.symbol_valid <= hold.symbol_valid;
      out_data.class_index <= hold.class_index;
      out_data.symbol_score <= hold.symbol_score;
      out_data.is_final <= hold.is_final;
      out_data.average_score <= avg;
    end else if (accept && row_done && !in_data.sequence_end) begin
      out_data.symbol_valid <= emit;
      out_data.class_index <= upd_index;
      out_data.symbol_score <= upd_score;
      out_data.is_final <= 1'b0;
      out_data.average_score <= '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_RUN |-> !accept)
    else $error("transaction accepted while divider busy");

  a_seq_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.sequence_end |=> column == '0 && !previous_valid && symbol_count == '0)
    else $error("sequence state not cleared at sequence end");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_final |-> out_data.average_score == '0)
    else $error("average on a non-final transaction");

  a_symbol_nonblank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.symbol_valid |-> out_data.class_index != '0)
    else $error("blank emitted as symbol");

  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> $past(state) == ST_DIV || $past(state) == ST_LOAD)
    else $error("load without a divide");
`endif

endmodule
`default_nettype wire

// File: dv/ctc_greedy_decoder_top_tb.sv
// testbench for the greedy ctc decoder: directed and random streams checked against a predictor
`timescale 1ns / 100ps
module ctc_greedy_decoder_top_tb
  import ctcgd_pkg::*;
();

  localparam int CLASS_LIMIT = 8192;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 55;

  class ctc_path_scoreboard;
    int class_limit;
    int key_count;
    int best_score;
    int best_index;
    int column;
    int prev_index;
    bit prev_valid;
    int score_total;
    int symbol_count;
    int errors;
    ctc_out_t expected_q[$];

    function new(int limit);
      class_limit = limit;
      key_count = KEY_COUNT_RESET;
      best_score = 0;
      best_index = 0;
      column = 0;
      prev_index = 0;
      prev_valid = 1'b0;
      score_total = 0;
      symbol_count = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_score(ctc_in_t item);
      int score;
      int avg;
      bit emit;
      ctc_out_t want;
      score = $signed(item.class_score);
      if (column == 0) begin
        best_score = score;
        best_index = 0;
      end else if (column < class_limit && score > best_score) begin
        best_score = score;
        best_index = column;
      end
      if (column < class_limit) column++;
      if (!item.row_end && !item.sequence_end) return;

      emit = (!prev_valid || best_index != prev_index) && best_index != 0 &&
             best_index < key_count;
      if (emit) begin
        score_total += best_score;
        if (score_total > SUM_MAX) score_total = SUM_MAX;
        if (score_total < SUM_MIN) score_total = SUM_MIN;
        if (symbol_count < COUNT_MAX) symbol_count++;
      end
      prev_index = best_index;
      prev_valid = 1'b1;
      column = 0;

      avg = 0;
      if (item.sequence_end && symbol_count > 0) begin
        avg = score_total / symbol_count;
        if (avg > AVG_MAX) avg = AVG_MAX;
        if (avg < AVG_MIN) avg = AVG_MIN;
      end
      want.symbol_valid = emit;
      want.class_index = best_index[12:0];
      want.symbol_score = best_score[15:0];
      want.is_final = item.sequence_end;
      want.average_score = avg[15:0];
      expected_q.insert(expected_q.size(), want);

      if (item.sequence_end) begin
        prev_index = 0;
        prev_valid = 1'b0;
        score_total = 0;
        symbol_count = 0;
      end
    endfunction

    function void check_field(string field, logic signed [31:0] want,
                              logic signed [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        errors++;
      end
    endfunction

    function void check_symbol(ctc_out_t got);
      ctc_out_t want;
      if (expected_q.size() == 0) begin
        $error("class_index %0d: unexpected transaction", got.class_index);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("symbol_valid", want.symbol_valid, got.symbol_valid);
      check_field("class_index", want.class_index, got.class_index);
      check_field("symbol_score", $signed(want.symbol_score), $signed(got.symbol_score));
      check_field("is_final", want.is_final, got.is_final);
      check_field("average_score", $signed(want.average_score),
                  $signed(got.average_score));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ctc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ctc_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ctc_path_scoreboard board = new(CLASS_LIMIT);
  bit gaps_on = 1'b1;
  int sent_items = 0;

  ctc_greedy_decoder_top #(
    .MAX_CLASSES(CLASS_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int random_score();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 15)) - 8;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  initial begin : stall_gen
    int run;
    forever begin
      @(posedge clk);
      out_stall <= 1'b0;
      if ($urandom_range(0, 4) == 0) run = $urandom_range(30, 100);
      else run = $urandom_range(1, 4);
      repeat (run) @(posedge clk);
      run = idle_length();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_symbol(out_data);
  end

  task automatic send_score(input ctc_in_t item);
    int idle;
    idle = gaps_on ? idle_length() : 0;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    board.note_score(item);
    sent_items++;
  endtask

  task automatic send_row(input int scores[$], input bit last_row, input bit bare_end);
    ctc_in_t item;
    foreach (scores[i]) begin
      item.class_score = 16'(scores[i]);
      item.row_end = (i == scores.size() - 1) && !(last_row && bare_end);
      item.sequence_end = (i == scores.size() - 1) && last_row;
      send_score(item);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_count(input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(REG_KEY_COUNT));
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.key_count = value;
  endtask

  task automatic send_random_sequence();
    int rows;
    int len;
    int pick;
    bit bare;
    int scores[$];
    int last_scores[$];
    rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    bare = ($urandom_range(0, 4) == 0);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int r = 0; r < rows; r++) begin
      if (r > 0 && $urandom_range(0, 3) == 0) begin
        scores = last_scores;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 15) len = $urandom_range(1, 8);
        else if (pick < 19) len = $urandom_range(9, 30);
        else len = $urandom_range(31, 120);
        scores.delete();
        repeat (len) scores.insert(scores.size(), random_score());
      end
      send_row(scores, r == rows - 1, bare);
      last_scores = scores;
    end
    if ($urandom_range(0, 9) == 0) drain();
  endtask

  initial begin : timeout
    #200_000_000;
    $display("ctc_greedy_decoder_top_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int row[$];
    int phase_keys[$];
    int phase_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_key_count(KEY_COUNT_RESET);

    // first max kept on ties, repeated argmax, blank, sequence end without row end
    row = '{5, 100, 100};
    send_row(row, 1'b0, 1'b0);
    row = '{-32768, 32767};
    send_row(row, 1'b0, 1'b0);
    row = '{7, 7};
    send_row(row, 1'b0, 1'b0);
    row = '{3, -2, 7, 7};
    send_row(row, 1'b1, 1'b1);
    // first row of a sequence always counts as new
    row = '{1, 0, 9};
    send_row(row, 1'b1, 1'b0);
    // no symbol in the sequence
    row = '{-4};
    send_row(row, 1'b1, 1'b0);
    // negative mean over two symbols
    row = '{-32768, -5};
    send_row(row, 1'b0, 1'b0);
    row = '{-9, -9, -7};
    send_row(row, 1'b1, 1'b0);
    drain();

    write_key_count(2);
    row = '{0, 0, 5};
    send_row(row, 1'b0, 1'b0);
    row = '{0, 5};
    send_row(row, 1'b1, 1'b0);
    drain();

    phase_keys = '{1, 3, 8191, 0, 6, 2, 8192};
    phase_keys.insert(4, $urandom_range(2, 60));
    foreach (phase_keys[p]) begin
      write_key_count(phase_keys[p]);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) send_random_sequence();
      drain();
    end

    if (board.errors == 0) begin
      $display("ctc_greedy_decoder_top_tb: done, clean");
    end else begin
      $display("ctc_greedy_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ctcgd_pkg.sv
sv/ctc_greedy_decoder_top.sv
dv/ctc_greedy_decoder_top_tb.sv
